@@ rtl/dfr_pkg.sv @@
// Package: DES round tables and helper functions.
package dfr_pkg;

   localparam int HalfWidth = 32;
   localparam int KeyWidth  = 24;
   localparam int ExpWidth  = 48;
   localparam int ReqWidth  = 112;
   localparam int RspWidth  = 64;

   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [ExpWidth-1:0]  exp_type;

   typedef logic [5:0] e_pos_type [ExpWidth];
   typedef logic [4:0] p_pos_type [HalfWidth];
   typedef logic [3:0] sbox_type [8][64];

   // Table entries are 1-based positions counted from the MSB.
   localparam e_pos_type ETab = '{
      6'd32, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
      6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   // Stored as (position - 1).
   localparam p_pos_type PTab = '{
      5'd15, 5'd6, 5'd19, 5'd20, 5'd28, 5'd11, 5'd27, 5'd16,
      5'd0, 5'd14, 5'd22, 5'd25, 5'd4, 5'd17, 5'd30, 5'd9,
      5'd1, 5'd7, 5'd23, 5'd13, 5'd31, 5'd26, 5'd2, 5'd8,
      5'd18, 5'd12, 5'd29, 5'd5, 5'd21, 5'd10, 5'd3, 5'd24
   };

   localparam sbox_type STab = '{
      '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
        4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1, 4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
        4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
        4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
      '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
        4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14, 4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
        4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
        4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
      '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
        4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10, 4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
        4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
        4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
      '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
        4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3, 4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
        4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
        4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
      '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
        4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1, 4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
        4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
        4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
      '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
        4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5, 4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
        4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
        4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
      '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
        4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10, 4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
        4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
        4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
      '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
        4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4, 4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
        4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
        4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
   };

   function automatic exp_type expand(input half_type r);
      exp_type e;
      for (int i = 0; i < ExpWidth; i++) begin
         e[ExpWidth-1-i] = r[5'(6'd32 - ETab[i])];
      end
      return e;
   endfunction

   function automatic half_type permute(input half_type v);
      half_type p;
      for (int i = 0; i < HalfWidth; i++) begin
         p[HalfWidth-1-i] = v[5'd31 - PTab[i]];
      end
      return p;
   endfunction

endpackage

@@ rtl/dfr_sbox.sv @@
// S-box layer: eight 6-to-4 DES substitutions.
module dfr_sbox
   import dfr_pkg::*;
(
   input  exp_type  sbox_in,
   output half_type sbox_out
);

   always_comb begin
      logic [5:0] g;
      for (int i = 0; i < 8; i++) begin
         g = sbox_in[47-6*i -: 6];
         sbox_out[31-4*i -: 4] = STab[i][{g[5], g[0], g[4:1]}];
      end
   end

endmodule

@@ rtl/dfr_round.sv @@
// Round datapath: expansion, key mix, substitution, permutation, left mix.
module dfr_round
   import dfr_pkg::*;
(
   input  half_type          right_in,
   input  half_type          left_in,
   input  logic [KeyWidth-1:0] key_high,
   input  logic [KeyWidth-1:0] key_low,
   output half_type          right_out,
   output half_type          left_out
);

   exp_type  mixed;
   half_type sbox_q;

   assign mixed = expand(right_in) ^ {key_high, key_low};

   dfr_sbox u_sbox (
      .sbox_in  (mixed),
      .sbox_out (sbox_q)
   );

   assign right_out = left_in ^ permute(sbox_q);
   assign left_out  = right_in;

endmodule

@@ rtl/feistel_block_cipher_round.sv @@
// Top level: one registered DES Feistel round on stream channels.
//
// Input items arrive on req_ (tdata: right_in, left_in, key_high, key_low
// from bit 0 up). Results leave on rsp_ (tdata: right_out, left_out).
// The round is combinational between an input register and an output
// register; an item's result is valid once it has passed through both.
// Throughput is one item per cycle: both stages advance together whenever
// the stage ahead is empty or being drained, so the pipe flows
// back to back with a ready path that is one AND chain deep.
// When the receiver stalls, the output register holds its item and the
// input register can still take one more item; req_tready drops only when
// both stages are full.
// Reset clears both valid flags; no results are pending afterward.
// The block keeps no state between items.
module feistel_block_cipher_round
   import dfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // right_in[31:0], left_in[63:32], key_high[87:64], key_low[111:88]
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // right_out[31:0], left_out[63:32]
   output logic [RspWidth-1:0] rsp_tdata
);

   logic                in_vld_ff, in_vld_in;
   logic [ReqWidth-1:0] in_data_ff;
   logic                out_vld_ff, out_vld_in;
   logic [RspWidth-1:0] out_data_ff;
   logic                out_adv, in_adv;
   half_type            right_q, left_q;

   assign out_adv    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || out_adv;
   assign in_adv     = req_tvalid && req_tready;

   assign in_vld_in  = in_adv || (in_vld_ff && !out_adv);
   assign out_vld_in = out_adv || (out_vld_ff && !rsp_tready);

   dfr_round u_round (
      .right_in  (in_data_ff[31:0]),
      .left_in   (in_data_ff[63:32]),
      .key_high  (in_data_ff[87:64]),
      .key_low   (in_data_ff[111:88]),
      .right_out (right_q),
      .left_out  (left_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (in_adv) begin
         in_data_ff <= req_tdata;
      end
      if (out_adv) begin
         out_data_ff <= {left_q, right_q};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(out_data_ff))
      else $error("result changed under stall");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_tready |-> !req_tready)
      else $error("accept while both stages full");

   a_left_pass: assert property (@(posedge clock) disable iff (reset)
      out_adv |=> out_data_ff[63:32] == $past(in_data_ff[31:0]))
      else $error("left_out mismatch");

endmodule
